FILE: hw/rtl/pidaw_pkg.sv
// ----------------------------------------------------------------------------
// pidaw_pkg
// Shared widths, codes, reset values and word types for the PID regulator
// with derivative on measurement and integral anti-windup.
// ----------------------------------------------------------------------------
package pidaw_pkg;

  localparam int DATA_WIDTH     = 16;
  localparam int GAIN_WIDTH     = 16;
  localparam int TIME_WIDTH     = 32;
  localparam int CFG_WIDTH      = 32;
  localparam int CFG_IDX_WIDTH  = 3;
  localparam int FRAC_BITS_DEF  = 8;

  localparam logic [GAIN_WIDTH-1:0]        GAIN_RST    = '0;
  localparam logic signed [DATA_WIDTH-1:0] OUT_MIN_RST = '0;
  localparam logic signed [DATA_WIDTH-1:0] OUT_MAX_RST = DATA_WIDTH'(255);
  localparam logic [TIME_WIDTH-1:0]        PERIOD_RST  = TIME_WIDTH'(100);

  typedef enum logic [1:0] {
    CMD_COMPUTE = 2'd0,
    CMD_AUTO    = 2'd1,
    CMD_MANUAL  = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    CFG_KP      = 3'd0,
    CFG_KI      = 3'd1,
    CFG_KD      = 3'd2,
    CFG_REVERSE = 3'd3,
    CFG_OUT_MIN = 3'd4,
    CFG_OUT_MAX = 3'd5,
    CFG_PERIOD  = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    cmd_e                          command;
    logic [TIME_WIDTH-1:0]         now;
    logic signed [DATA_WIDTH-1:0]  measurement;
    logic signed [DATA_WIDTH-1:0]  target;
    logic signed [DATA_WIDTH-1:0]  current_output;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0]  control_output;
    logic                          updated;
    logic                          auto_mode;
  } out_word_t;

  typedef struct packed {
    logic [GAIN_WIDTH-1:0]         kp_gain;
    logic [GAIN_WIDTH-1:0]         ki_gain;
    logic [GAIN_WIDTH-1:0]         kd_gain;
    logic                          reverse_direction;
    logic signed [DATA_WIDTH-1:0]  out_min;
    logic signed [DATA_WIDTH-1:0]  out_max;
    logic [TIME_WIDTH-1:0]         sample_period;
  } cfg_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0]  prev_meas;
    logic [TIME_WIDTH-1:0]         prev_time;
    logic                          first_due;
    logic                          auto_on;
  } ctrl_state_t;

endpackage

FILE: hw/rtl/pidaw_core.sv
// ----------------------------------------------------------------------------
// pidaw_core
// Single pass update: gains, error terms, integral clamp, output clamp and
// floor, plus the mode and timing state for the next word.
// ----------------------------------------------------------------------------
module pidaw_core #(
  parameter int FRAC_BITS = pidaw_pkg::FRAC_BITS_DEF
) (
  input  pidaw_pkg::in_word_t                                 item_i,
  input  pidaw_pkg::cfg_t                                     cfg_i,
  input  pidaw_pkg::ctrl_state_t                              state_i,
  input  logic signed [pidaw_pkg::DATA_WIDTH+FRAC_BITS-1:0]   integ_i,
  output pidaw_pkg::ctrl_state_t                              state_o,
  output logic signed [pidaw_pkg::DATA_WIDTH+FRAC_BITS-1:0]   integ_o,
  output pidaw_pkg::out_word_t                                result_o
);

  localparam int DW  = pidaw_pkg::DATA_WIDTH;
  localparam int IW  = DW + FRAC_BITS;
  localparam int GSW = pidaw_pkg::GAIN_WIDTH + 1;
  localparam int ESW = DW + 1;
  localparam int PW  = GSW + ESW;
  localparam int SW  = PW + 2;

  // upper limit tested first
  function automatic logic signed [IW-1:0] clamp_lim(
    input logic signed [SW-1:0] v,
    input logic signed [SW-1:0] hi,
    input logic signed [SW-1:0] lo
  );
    logic signed [SW-1:0] r;
    if (v > hi) begin
      r = hi;
    end else if (v < lo) begin
      r = lo;
    end else begin
      r = v;
    end
    return r[IW-1:0];
  endfunction

  logic signed [GSW-1:0] kp_s, ki_s, kd_s;
  logic signed [ESW-1:0] err, dmeas;
  logic signed [PW-1:0]  p_term, i_term, d_term;
  logic signed [IW-1:0]  hi_sc, lo_sc, cur_sc;
  logic signed [SW-1:0]  hi_w, lo_w;
  logic signed [IW-1:0]  integ_new, seed, sum_cl;
  logic signed [SW-1:0]  sum;
  logic [pidaw_pkg::TIME_WIDTH-1:0] elapsed;
  logic                  fire;

  always_comb begin
    kp_s = $signed({1'b0, cfg_i.kp_gain});
    ki_s = $signed({1'b0, cfg_i.ki_gain});
    kd_s = $signed({1'b0, cfg_i.kd_gain});
    if (cfg_i.reverse_direction) begin
      kp_s = -kp_s;
      ki_s = -ki_s;
      kd_s = -kd_s;
    end
  end

  assign err    = ESW'(item_i.target) - ESW'(item_i.measurement);
  assign dmeas  = ESW'(item_i.measurement) - ESW'(state_i.prev_meas);

  assign p_term = PW'(kp_s) * PW'(err);
  assign i_term = PW'(ki_s) * PW'(err);
  assign d_term = PW'(kd_s) * PW'(dmeas);

  assign hi_sc  = $signed({cfg_i.out_max, {FRAC_BITS{1'b0}}});
  assign lo_sc  = $signed({cfg_i.out_min, {FRAC_BITS{1'b0}}});
  assign cur_sc = $signed({item_i.current_output, {FRAC_BITS{1'b0}}});
  assign hi_w   = SW'(hi_sc);
  assign lo_w   = SW'(lo_sc);

  assign integ_new = clamp_lim(SW'(integ_i) + SW'(i_term), hi_w, lo_w);
  assign sum       = SW'(p_term) + SW'(integ_new) - SW'(d_term);
  assign sum_cl    = clamp_lim(sum, hi_w, lo_w);
  assign seed      = clamp_lim(SW'(cur_sc), hi_w, lo_w);

  assign elapsed = item_i.now - state_i.prev_time;
  assign fire    = (item_i.command == pidaw_pkg::CMD_COMPUTE) && state_i.auto_on &&
                   (state_i.first_due || (elapsed >= cfg_i.sample_period));

  always_comb begin
    state_o = state_i;
    integ_o = integ_i;
    case (item_i.command)
      pidaw_pkg::CMD_COMPUTE: begin
        if (fire) begin
          integ_o           = integ_new;
          state_o.prev_meas = item_i.measurement;
          state_o.prev_time = item_i.now;
          state_o.first_due = 1'b0;
        end
      end
      pidaw_pkg::CMD_AUTO: begin
        if (!state_i.auto_on) begin
          integ_o           = seed;
          state_o.prev_meas = item_i.measurement;
        end
        state_o.auto_on = 1'b1;
      end
      pidaw_pkg::CMD_MANUAL: begin
        state_o.auto_on = 1'b0;
      end
      pidaw_pkg::CMD_CLEAR: begin
        integ_o = '0;
      end
      default: begin
        state_o = state_i;
      end
    endcase
  end

  // arithmetic floor of the clamped sum, zero when no update fires
  assign result_o.control_output = fire ? sum_cl[FRAC_BITS +: DW] : '0;
  assign result_o.updated        = fire;
  assign result_o.auto_mode      = state_o.auto_on;

endmodule

FILE: hw/rtl/pid_controller_antiwindup.sv
// ----------------------------------------------------------------------------
// pid_controller_antiwindup
// PID regulator with derivative on measurement, integral clamp and output
// clamp, one result word for every input word.
// ----------------------------------------------------------------------------
// Takes one word per clock while the output side is not stalled, and returns
// one result word per input word: the word is captured in an input register,
// passes once through the three 17x17 multipliers, the integral clamp and
// the output clamp, and lands in the result register together with the
// updated integral, mode and timing state.
// A stalled output register holds the input side after one more word.
// The user must write registers through the config port only while no word
// is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module pid_controller_antiwindup #(
  parameter int FRAC_BITS = pidaw_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  pidaw_pkg::in_word_t                    in_data_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output pidaw_pkg::out_word_t                   out_data_o,
  input  logic                                   cfg_we_i,
  input  logic [pidaw_pkg::CFG_IDX_WIDTH-1:0]    cfg_idx_i,
  input  logic [pidaw_pkg::CFG_WIDTH-1:0]        cfg_wdata_i
);

  localparam int DW = pidaw_pkg::DATA_WIDTH;
  localparam int IW = DW + FRAC_BITS;
  localparam int GW = pidaw_pkg::GAIN_WIDTH;
  localparam int TW = pidaw_pkg::TIME_WIDTH;

  pidaw_pkg::cfg_t        cfg_q;
  pidaw_pkg::ctrl_state_t state_q, state_d;
  logic signed [IW-1:0]   integ_q, integ_d;
  pidaw_pkg::in_word_t    in_q;
  logic                   in_valid_q;
  pidaw_pkg::out_word_t   out_q, res_d;
  logic                   out_valid_q;
  logic                   adv;

  assign adv        = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || adv;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kp_gain           <= pidaw_pkg::GAIN_RST;
      cfg_q.ki_gain           <= pidaw_pkg::GAIN_RST;
      cfg_q.kd_gain           <= pidaw_pkg::GAIN_RST;
      cfg_q.reverse_direction <= 1'b0;
      cfg_q.out_min           <= pidaw_pkg::OUT_MIN_RST;
      cfg_q.out_max           <= pidaw_pkg::OUT_MAX_RST;
      cfg_q.sample_period     <= pidaw_pkg::PERIOD_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pidaw_pkg::CFG_KP:      cfg_q.kp_gain           <= cfg_wdata_i[GW-1:0];
        pidaw_pkg::CFG_KI:      cfg_q.ki_gain           <= cfg_wdata_i[GW-1:0];
        pidaw_pkg::CFG_KD:      cfg_q.kd_gain           <= cfg_wdata_i[GW-1:0];
        pidaw_pkg::CFG_REVERSE: cfg_q.reverse_direction <= cfg_wdata_i[0];
        pidaw_pkg::CFG_OUT_MIN: cfg_q.out_min           <= $signed(cfg_wdata_i[DW-1:0]);
        pidaw_pkg::CFG_OUT_MAX: cfg_q.out_max           <= $signed(cfg_wdata_i[DW-1:0]);
        pidaw_pkg::CFG_PERIOD:  cfg_q.sample_period     <= cfg_wdata_i[TW-1:0];
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= (in_valid_i && in_ready_o) || (in_valid_q && !adv);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  pidaw_core #(
    .FRAC_BITS (FRAC_BITS)
  ) u_core (
    .item_i   (in_q),
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .integ_i  (integ_q),
    .state_o  (state_d),
    .integ_o  (integ_d),
    .result_o (res_d)
  );

  // controller state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.prev_meas <= '0;
      state_q.prev_time <= '0;
      state_q.first_due <= 1'b1;
      state_q.auto_on   <= 1'b0;
      integ_q           <= '0;
    end else if (adv) begin
      state_q <= state_d;
      integ_q <= integ_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= adv || (out_valid_q && !out_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_upd_auto : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.updated |-> out_data_o.auto_mode)
    else $error("result updated outside automatic mode");

  a_idle_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.updated |-> out_data_o.control_output == '0)
    else $error("non-zero output without a computation");

  a_first_due : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(state_q.first_due) |-> $past(adv && res_d.updated))
    else $error("first-due flag cleared without a computation");

  a_stall_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> in_valid_q && out_valid_q && !out_ready_i)
    else $error("input side stalled without a full pipeline");

endmodule
